>>> sv/fbb_pkg.sv
`timescale 1ns / 1ps
package fbb_pkg;

  localparam int MAX_SIZE    = 1024;
  localparam int WINDOW      = 3;
  localparam int NUM_CH      = 3;
  localparam int CH_W        = 16;
  localparam int COL_W       = $clog2(MAX_SIZE);
  localparam int SIZE_W      = 11;
  localparam int SLOT_W      = 2;
  localparam int OFS_W       = 2;
  localparam int SUM_W       = 20;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(1 << RECIP_SHIFT);
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << RECIP_SHIFT) + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << RECIP_SHIFT) + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << RECIP_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;
  typedef pix_t [WINDOW-1:0] line_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  addr;
    pix_t              data;
  } line_wr_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_req_t;

  typedef struct packed {
    logic [COL_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic             last_of_run;
  } out_req_t;

  // Scaled reciprocal of the window pixel count (di + 1) * (dj + 1).
  function automatic logic [RECIP_W-1:0] fbb_recip(input logic [OFS_W-1:0] di,
                                                   input logic [OFS_W-1:0] dj);
    logic [2*OFS_W-1:0] key;
    logic [RECIP_W-1:0] r;
    key = {di, dj};
    case (key)
      4'b0000:          r = RECIP_1;
      4'b0001, 4'b0100: r = RECIP_2;
      4'b0010, 4'b1000: r = RECIP_3;
      4'b0101:          r = RECIP_4;
      4'b0110, 4'b1001: r = RECIP_6;
      4'b1010:          r = RECIP_9;
      default:          r = RECIP_1;
    endcase
    return r;
  endfunction

endpackage

>>> sv/fbb_line_store.sv
`timescale 1ns / 1ps
module fbb_line_store
  import fbb_pkg::*;
(
  input  logic             clk_i,
  input  line_wr_t         wr_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output line_t            rd_data_o
);

  // One word per column holds that column of all three row slots.
  line_t mem_q [MAX_SIZE];
  line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr][wr_i.slot] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/forward_box_blur_3x3_unit.sv
`timescale 1ns / 1ps
// A request that completes no window only writes the line store and leaves the unit idle.
// Each result takes a line store read and an accumulate state per window column, then a
// divide state that waits while the output register is stalled.
// Throughput is set by the single read port of the line store and the shared divider.
// Reset clears the control state, sets the image size to 64 and the position to the
// origin; the line store is not cleared, as every window reads only pixels already written.
module forward_box_blur_3x3_unit
  import fbb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_req_t          out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_ACC  = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [COL_W-1:0]  nm1_q, nm1_d;
  logic [COL_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;

  logic [COL_W-1:0]  pix_row_q, pix_row_d;
  logic [COL_W-1:0]  pix_col_q, pix_col_d;
  logic [SLOT_W-1:0] pix_slot_q, pix_slot_d;
  logic [OFS_W-1:0]  di_q, di_d;
  logic [OFS_W-1:0]  dj_q, dj_d;
  logic [OFS_W-1:0]  dj_hi_q, dj_hi_d;
  logic [OFS_W-1:0]  di_lo_q, di_lo_d;
  logic [OFS_W-1:0]  dj_lo_q, dj_lo_d;
  logic [OFS_W-1:0]  xo_q, xo_d;
  logic [SUM_W-1:0]  sum_q [NUM_CH];
  logic [SUM_W-1:0]  sum_d [NUM_CH];

  logic              out_valid_q, out_valid_d;
  out_req_t          out_q, out_d;

  logic              in_acc;
  logic              last_r, last_c, any_r, any_c;
  logic [OFS_W-1:0]  di_hi, dj_hi, di_lo, dj_lo;
  logic              last_origin, out_load;
  logic [SIZE_W-1:0] cfg_m1;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [SUM_W-1:0]  acc [NUM_CH];

  line_wr_t          wr;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  line_t             rd_data;

  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input logic [OFS_W-1:0] d);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + (SLOT_W+1)'(WINDOW) - {1'b0, d};
    if (t >= (SLOT_W+1)'(WINDOW)) begin
      t = t - (SLOT_W+1)'(WINDOW);
    end
    return t[SLOT_W-1:0];
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  // Origins completed by the current pixel, as backward offsets from it.
  assign last_r = (row_q == nm1_q);
  assign last_c = (col_q == nm1_q);
  assign any_r  = last_r || (row_q >= COL_W'(2));
  assign any_c  = last_c || (col_q >= COL_W'(2));
  assign di_hi  = (last_r && (row_q < COL_W'(2))) ? row_q[OFS_W-1:0] : OFS_W'(2);
  assign dj_hi  = (last_c && (col_q < COL_W'(2))) ? col_q[OFS_W-1:0] : OFS_W'(2);
  assign di_lo  = last_r ? OFS_W'(0) : OFS_W'(2);
  assign dj_lo  = last_c ? OFS_W'(0) : OFS_W'(2);

  assign wr.en   = in_acc;
  assign wr.slot = rslot_q;
  assign wr.addr = col_q;
  assign wr.data = {in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};

  assign rd_en   = (state_q == S_RD);
  assign rd_addr = pix_col_q - COL_W'(xo_q);

  fbb_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      acc[k] = sum_q[k];
      for (int d = 0; d < WINDOW; d++) begin
        if (OFS_W'(d) <= di_q) begin
          acc[k] = acc[k] + SUM_W'(rd_data[slot_back(pix_slot_q, OFS_W'(d))][k]);
        end
      end
    end
  end

  assign recip = fbb_recip(di_q, dj_q);
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] = PROD_W'(sum_q[k]) * PROD_W'(recip);
    end
  end

  assign last_origin = (di_q == di_lo_q) && (dj_q == dj_lo_q);
  assign out_load    = (state_q == S_DIV) && (!out_valid_q || !out_stall_i);
  assign cfg_m1      = cfg_wdata_i - SIZE_W'(1);

  always_comb begin
    nm1_d   = nm1_q;
    row_d   = row_q;
    col_d   = col_q;
    rslot_d = rslot_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        nm1_d = '0;
      end else if (cfg_wdata_i > SIZE_MAX) begin
        nm1_d = COL_W'(MAX_SIZE - 1);
      end else begin
        nm1_d = cfg_m1[COL_W-1:0];
      end
      row_d   = '0;
      col_d   = '0;
      rslot_d = '0;
    end else if (in_acc) begin
      if (last_c) begin
        col_d = '0;
        if (last_r) begin
          row_d   = '0;
          rslot_d = '0;
        end else begin
          row_d   = row_q + COL_W'(1);
          rslot_d = (rslot_q == SLOT_W'(WINDOW - 1)) ? '0 : rslot_q + SLOT_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    pix_row_d  = pix_row_q;
    pix_col_d  = pix_col_q;
    pix_slot_d = pix_slot_q;
    di_d       = di_q;
    dj_d       = dj_q;
    dj_hi_d    = dj_hi_q;
    di_lo_d    = di_lo_q;
    dj_lo_d    = dj_lo_q;
    xo_d       = xo_q;
    sum_d      = sum_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc && any_r && any_c) begin
          pix_row_d  = row_q;
          pix_col_d  = col_q;
          pix_slot_d = rslot_q;
          di_d       = di_hi;
          dj_d       = dj_hi;
          dj_hi_d    = dj_hi;
          di_lo_d    = di_lo;
          dj_lo_d    = dj_lo;
          xo_d       = dj_hi;
          for (int k = 0; k < NUM_CH; k++) begin
            sum_d[k] = '0;
          end
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = acc;
        if (xo_q == '0) begin
          state_d = S_DIV;
        end else begin
          xo_d    = xo_q - OFS_W'(1);
          state_d = S_RD;
        end
      end
      S_DIV: begin
        if (out_load) begin
          out_valid_d       = 1'b1;
          out_d.out_row     = pix_row_q - COL_W'(di_q);
          out_d.out_col     = pix_col_q - COL_W'(dj_q);
          out_d.out_red     = prod[0][RECIP_SHIFT +: CH_W];
          out_d.out_green   = prod[1][RECIP_SHIFT +: CH_W];
          out_d.out_blue    = prod[2][RECIP_SHIFT +: CH_W];
          out_d.last_of_run = last_origin;
          for (int k = 0; k < NUM_CH; k++) begin
            sum_d[k] = '0;
          end
          if (last_origin) begin
            state_d = S_IDLE;
          end else if (dj_q != dj_lo_q) begin
            dj_d    = dj_q - OFS_W'(1);
            xo_d    = dj_q - OFS_W'(1);
            state_d = S_RD;
          end else begin
            dj_d    = dj_hi_q;
            di_d    = di_q - OFS_W'(1);
            xo_d    = dj_hi_q;
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nm1_q       <= COL_W'(SIZE_RESET - SIZE_W'(1));
      row_q       <= '0;
      col_q       <= '0;
      rslot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nm1_q       <= nm1_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rslot_q     <= rslot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_row_q  <= pix_row_d;
    pix_col_q  <= pix_col_d;
    pix_slot_q <= pix_slot_d;
    di_q       <= di_d;
    dj_q       <= dj_d;
    dj_hi_q    <= dj_hi_d;
    di_lo_q    <= di_lo_d;
    dj_lo_q    <= dj_lo_d;
    xo_q       <= xo_d;
    sum_q      <= sum_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= nm1_q) && (col_q <= nm1_q))
    else $error("position left the image");

  a_read_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (xo_q <= dj_q) && (COL_W'(dj_q) <= pix_col_q))
    else $error("line store read outside the window");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && out_valid_q && out_stall_i |=>
      (state_q == S_DIV) && $stable(di_q) && $stable(dj_q))
    else $error("sequencer moved on while the result register was blocked");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we_i && !last_c |=> col_q == $past(col_q) + COL_W'(1))
    else $error("column position did not advance");

endmodule
